// File: src/shortest_remaining_time_scheduler_unit_macros.svh
// assertion macros for the scheduler
`ifndef SHORTEST_REMAINING_TIME_SCHEDULER_UNIT_MACROS_SVH
`define SHORTEST_REMAINING_TIME_SCHEDULER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SRTS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SRTS_ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`else
`define SRTS_ASSERT(label, clk, rst_n, prop, msg)
`define SRTS_ASSERT_IMPL(label, clk, rst_n, a, c, msg)
`endif
`endif

// File: src/srts_pkg.sv
// ----------------------------------------------------------------------------
// srts_pkg
// shared constants and types of the shortest-remaining-time scheduler
// ----------------------------------------------------------------------------
package srts_pkg;
	localparam int SLOTS     = 16;
	localparam int SLOT_BITS = $clog2(SLOTS);
	localparam int TIME_BITS = 16;
	localparam int ID_BITS   = 8;
	localparam int CNT_BITS  = $clog2(SLOTS + 1);

	localparam logic OP_ADMIT = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [SLOT_BITS-1:0] slot_t;

	// one slot entry as held in the table memory
	typedef struct packed {
		logic [ID_BITS-1:0] task_id;
		time_t              admit_time;
		time_t              burst;
		time_t              remaining;
		time_t              first_dispatch;
	} entry_t;

	// memory port between controller and table
	typedef struct packed {
		logic   rd_en;
		slot_t  rd_addr;
		logic   wr_en;
		slot_t  wr_addr;
		entry_t wr_data;
	} mem_req_t;

	function automatic time_t sat_inc(input time_t v);
		return (v == '1) ? v : time_t'(v + 1'b1);
	endfunction

	function automatic time_t sat_sub(input time_t a, input time_t b);
		return (a > b) ? time_t'(a - b) : '0;
	endfunction
endpackage

// File: src/shortest_remaining_time_scheduler_unit.sv
// ----------------------------------------------------------------------------
// shortest_remaining_time_scheduler_unit
// preemptive shortest-remaining-time-first scheduler over a slot table memory
// ----------------------------------------------------------------------------
// channel | direction | handshake             | payload
// in      | input     | in_valid / in_ready   | operation, task_id, burst_length
// out     | output    | out_valid / out_ready | admit_ok ... turnaround_time
//
// an admit shows its result in the cycle after it is taken; a tick first runs the
// scan (ST_SCAN, then ST_LAST for the final slot) that reads every slot through
// the single table read port, then ST_RREAD and ST_RUN; an idle tick ends at ST_LAST.
// one item at a time; the next item is taken the cycle after the result is
// taken.
// reset clears slot valid and started flags, time and the running task;
// the table memory itself is not cleared.
module shortest_remaining_time_scheduler_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [7:0]  task_id,
	input  logic [15:0] burst_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        admit_ok,
	output logic        run_valid,
	output logic [7:0]  run_id,
	output logic        segment_valid,
	output logic [7:0]  segment_id,
	output logic [15:0] segment_length,
	output logic        done_valid,
	output logic [7:0]  done_id,
	output logic [15:0] completion_time,
	output logic [15:0] response_time,
	output logic [15:0] waiting_time,
	output logic [15:0] turnaround_time
);
	import srts_pkg::*;

	mem_req_t mem_req;
	entry_t   rd_data;

	srts_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .operation, .task_id, .burst_length,
		.out_valid, .out_ready, .admit_ok, .run_valid, .run_id, .segment_valid,
		.segment_id, .segment_length, .done_valid, .done_id, .completion_time,
		.response_time, .waiting_time, .turnaround_time, .mem_req, .rd_data
	);

	srts_table u_table (
		.clk, .req(mem_req), .rd_data
	);
endmodule

// File: src/srts_table.sv
// ----------------------------------------------------------------------------
// srts_table
// slot entry memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module srts_table (
	input  logic              clk,
	input  srts_pkg::mem_req_t req,
	output srts_pkg::entry_t  rd_data
);
	import srts_pkg::*;

	entry_t mem [SLOTS];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end
endmodule

// File: src/srts_ctrl.sv
// ----------------------------------------------------------------------------
// srts_ctrl
// sequencer: admit, remaining-time scan, update and report
// ----------------------------------------------------------------------------
`include "shortest_remaining_time_scheduler_unit_macros.svh"
module srts_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           operation,
	input  logic [srts_pkg::ID_BITS-1:0]   task_id,
	input  logic [15:0]                    burst_length,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           admit_ok,
	output logic                           run_valid,
	output logic [srts_pkg::ID_BITS-1:0]   run_id,
	output logic                           segment_valid,
	output logic [srts_pkg::ID_BITS-1:0]   segment_id,
	output logic [15:0]                    segment_length,
	output logic                           done_valid,
	output logic [srts_pkg::ID_BITS-1:0]   done_id,
	output logic [15:0]                    completion_time,
	output logic [15:0]                    response_time,
	output logic [15:0]                    waiting_time,
	output logic [15:0]                    turnaround_time,
	output srts_pkg::mem_req_t             mem_req,
	input  srts_pkg::entry_t               rd_data
);
	import srts_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_LAST  = 3'd2;
	localparam logic [2:0] ST_RREAD = 3'd3;
	localparam logic [2:0] ST_RUN   = 3'd4;

	logic [2:0]      state_q;
	logic [SLOTS-1:0] valid_q, started_q;
	time_t           now_q, seg_q;
	logic            run_q;
	slot_t           run_slot_q;
	slot_t           scan_q, prev_q;
	logic            best_v_q;
	slot_t           best_q;
	time_t           best_rem_q;
	entry_t          run_e_q;
	logic            has_run_q;
	logic            pend_q;

	// fields of the result register
	logic r_admit_q, r_run_q, r_seg_q, r_done_q;
	logic [ID_BITS-1:0] r_run_id_q, r_seg_id_q, r_done_id_q;
	time_t r_seg_len_q, r_comp_q, r_resp_q, r_wait_q, r_turn_q;

	logic [SLOTS-1:0] free_vec;
	logic             free_any;
	slot_t            free_slot;
	logic             take;
	logic             cand_ok;

	assign in_ready  = (state_q == ST_IDLE) && !pend_q;
	assign take      = in_valid && in_ready;
	assign out_valid = pend_q;

	always_comb begin
		free_vec  = ~valid_q;
		free_any  = |free_vec;
		free_slot = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (free_vec[i]) begin
				free_slot = slot_t'(i);
			end
		end
	end

	// a read data word belongs to prev_q; skip the running slot and empty slots
	assign cand_ok = valid_q[prev_q] && !(has_run_q && prev_q == run_slot_q);

	// next running entry values for the tick update
	entry_t e;
	time_t  now_n, seg_n, turn;
	slot_t  s;
	logic   preempt;
	always_comb begin
		preempt = has_run_q && best_v_q && (best_rem_q < run_e_q.remaining);
		s       = has_run_q ? (preempt ? best_q : run_slot_q) : best_q;
		e       = rd_data;
		if (!started_q[s]) begin
			e.first_dispatch = now_q;
		end
		if (e.remaining != '0) begin
			e.remaining = time_t'(e.remaining - 1'b1);
		end
		now_n = sat_inc(now_q);
		seg_n = sat_inc((has_run_q && !preempt) ? seg_q : '0);
		turn  = sat_sub(now_n, e.admit_time);
	end

	always_comb begin
		mem_req = '0;
		case (state_q)
			ST_IDLE: begin
				mem_req.rd_en   = take && operation == OP_TICK;
				mem_req.rd_addr = '0;
				if (take && operation == OP_ADMIT && burst_length != '0 && free_any) begin
					mem_req.wr_en                  = 1'b1;
					mem_req.wr_addr                = free_slot;
					mem_req.wr_data.task_id        = task_id;
					mem_req.wr_data.admit_time     = now_q;
					mem_req.wr_data.burst          = burst_length;
					mem_req.wr_data.remaining      = burst_length;
					mem_req.wr_data.first_dispatch = '0;
				end
			end
			ST_SCAN: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = scan_q;
			end
			ST_LAST: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = has_run_q ? run_slot_q : best_q;
			end
			ST_RREAD: begin
				// rd_data holds the running entry here when one runs; the winner is final
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = (has_run_q && !(best_v_q && best_rem_q < rd_data.remaining)) ?
					run_slot_q : best_q;
			end
			ST_RUN: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = s;
				mem_req.wr_data = e;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			started_q   <= '0;
			now_q       <= '0;
			seg_q       <= '0;
			run_q       <= 1'b0;
			run_slot_q  <= '0;
			pend_q      <= 1'b0;
			has_run_q   <= 1'b0;
			best_v_q    <= 1'b0;
			best_q      <= '0;
			best_rem_q  <= '0;
			scan_q      <= '0;
			prev_q      <= '0;
			run_e_q     <= '0;
			{r_admit_q, r_run_q, r_seg_q, r_done_q} <= '0;
			{r_run_id_q, r_seg_id_q, r_done_id_q} <= '0;
			{r_seg_len_q, r_comp_q, r_resp_q, r_wait_q, r_turn_q} <= '0;
		end else begin
			if (pend_q && out_ready) begin
				pend_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						{r_run_q, r_seg_q, r_done_q} <= '0;
						{r_run_id_q, r_seg_id_q, r_done_id_q} <= '0;
						{r_seg_len_q, r_comp_q, r_resp_q, r_wait_q, r_turn_q} <= '0;
						r_admit_q <= (operation == OP_ADMIT) && burst_length != '0 && free_any;
						if (operation == OP_ADMIT) begin
							pend_q <= 1'b1;
							if (burst_length != '0 && free_any) begin
								valid_q[free_slot]   <= 1'b1;
								started_q[free_slot] <= 1'b0;
							end
						end else begin
							has_run_q <= run_q && valid_q[run_slot_q];
							best_v_q  <= 1'b0;
							scan_q    <= slot_t'(1);
							prev_q    <= '0;
							state_q   <= (SLOTS == 1) ? ST_LAST : ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (cand_ok && (!best_v_q || rd_data.remaining < best_rem_q)) begin
						best_v_q   <= 1'b1;
						best_q     <= prev_q;
						best_rem_q <= rd_data.remaining;
					end
					prev_q <= scan_q;
					scan_q <= slot_t'(scan_q + 1'b1);
					if (scan_q == slot_t'(SLOTS - 1)) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					// fold the final slot; its read issues the running entry when one runs
					if (cand_ok && (!best_v_q || rd_data.remaining < best_rem_q)) begin
						best_v_q   <= 1'b1;
						best_q     <= prev_q;
						best_rem_q <= rd_data.remaining;
					end
					if (has_run_q) begin
						state_q <= ST_RREAD;
					end else if (cand_ok || best_v_q) begin
						// re-read winner: handled by RREAD with has_run_q low
						state_q <= ST_RREAD;
					end else begin
						now_q   <= sat_inc(now_q);
						run_q   <= 1'b0;
						seg_q   <= '0;
						pend_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_RREAD: begin
					run_e_q <= rd_data;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					pend_q     <= 1'b1;
					state_q    <= ST_IDLE;
					now_q      <= now_n;
					r_run_q    <= 1'b1;
					r_run_id_q <= e.task_id;
					if (preempt) begin
						r_seg_q     <= 1'b1;
						r_seg_id_q  <= run_e_q.task_id;
						r_seg_len_q <= seg_q;
					end
					if (e.remaining == '0) begin
						if (!preempt) begin
							r_seg_q     <= 1'b1;
							r_seg_id_q  <= e.task_id;
							r_seg_len_q <= seg_n;
						end
						r_done_q     <= 1'b1;
						r_done_id_q  <= e.task_id;
						r_comp_q     <= now_n;
						r_resp_q     <= sat_sub(e.first_dispatch, e.admit_time);
						r_wait_q     <= sat_sub(turn, e.burst);
						r_turn_q     <= turn;
						valid_q[s]   <= 1'b0;
						started_q[s] <= 1'b0;
						run_q        <= 1'b0;
						run_slot_q   <= '0;
						seg_q        <= '0;
					end else begin
						started_q[s] <= 1'b1;
						run_q        <= 1'b1;
						run_slot_q   <= s;
						seg_q        <= seg_n;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign admit_ok        = r_admit_q;
	assign run_valid       = r_run_q;
	assign run_id          = r_run_id_q;
	assign segment_valid   = r_seg_q;
	assign segment_id      = r_seg_id_q;
	assign segment_length  = r_seg_len_q;
	assign done_valid      = r_done_q;
	assign done_id         = r_done_id_q;
	assign completion_time = r_comp_q;
	assign response_time   = r_resp_q;
	assign waiting_time    = r_wait_q;
	assign turnaround_time = r_turn_q;

	`SRTS_ASSERT_IMPL(a_ready_idle, clk, arst_n, in_ready, state_q == ST_IDLE, "ready outside idle")
	`SRTS_ASSERT_IMPL(a_run_slot_valid, clk, arst_n, state_q == ST_RUN, valid_q[s], "runs an empty slot")
	`SRTS_ASSERT(a_done_clears, clk, arst_n, (state_q == ST_RUN && e.remaining == '0) |=> !valid_q[$past(s)], "finished slot kept")
	`SRTS_ASSERT(a_one_result, clk, arst_n, (pend_q && !out_ready) |=> pend_q, "result dropped")
endmodule

// File: test/shortest_remaining_time_scheduler_unit_test.sv
// ----------------------------------------------------------------------------
// shortest_remaining_time_scheduler_unit_test
// checks the scheduler item by item against a behavioral copy of the
// shortest-remaining-time policy, under random stalls on both channels
// ----------------------------------------------------------------------------
module shortest_remaining_time_scheduler_unit_test;
	import srts_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 1500000;

	typedef struct {
		logic        operation;
		logic [7:0]  task_id;
		logic [15:0] burst_length;
		bit          drain;
	} request_t;

	typedef struct {
		logic        admit_ok;
		logic        run_valid;
		logic [7:0]  run_id;
		logic        segment_valid;
		logic [7:0]  segment_id;
		logic [15:0] segment_length;
		logic        done_valid;
		logic [7:0]  done_id;
		logic [15:0] completion_time;
		logic [15:0] response_time;
		logic [15:0] waiting_time;
		logic [15:0] turnaround_time;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        operation;
	logic [7:0]  task_id;
	logic [15:0] burst_length;
	logic        out_valid;
	logic        out_ready;
	logic        admit_ok;
	logic        run_valid;
	logic [7:0]  run_id;
	logic        segment_valid;
	logic [7:0]  segment_id;
	logic [15:0] segment_length;
	logic        done_valid;
	logic [7:0]  done_id;
	logic [15:0] completion_time;
	logic [15:0] response_time;
	logic [15:0] waiting_time;
	logic [15:0] turnaround_time;

	shortest_remaining_time_scheduler_unit u_top (.*);

	// scheduler state as the predictor sees it
	bit          task_live [SLOTS];
	logic [7:0]  task_tag [SLOTS];
	time_t       task_arrival [SLOTS];
	time_t       task_burst [SLOTS];
	time_t       task_left [SLOTS];
	bit          task_started [SLOTS];
	time_t       task_first_run [SLOTS];
	time_t       now;
	bit          cpu_busy;
	int          cpu_slot;
	time_t       run_units;

	request_t    pending_items[$];
	outcome_t    expected_outcomes[$];
	int          mismatches;
	int          items_sent;
	int          total_items;
	int          cycles;

	function automatic time_t clamp_inc(time_t v);
		return (v == '1) ? v : time_t'(v + 1'b1);
	endfunction

	function automatic time_t clamp_sub(time_t a, time_t b);
		return (a > b) ? time_t'(a - b) : '0;
	endfunction

	function automatic int shortest_task(int skip);
		int best;
		best = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (task_live[i] && i != skip && (best < 0 || task_left[i] < task_left[best]))
				best = i;
		end
		return best;
	endfunction

	function automatic outcome_t schedule_item(request_t r);
		outcome_t o;
		int free_slot;
		int pick;
		time_t turn;
		o = '{default: '0};
		if (r.operation == OP_ADMIT) begin
			free_slot = -1;
			for (int i = 0; i < SLOTS; i++) begin
				if (!task_live[i] && free_slot < 0)
					free_slot = i;
			end
			if (r.burst_length != 0 && free_slot >= 0) begin
				task_live[free_slot] = 1;
				task_tag[free_slot] = r.task_id;
				task_arrival[free_slot] = now;
				task_burst[free_slot] = r.burst_length;
				task_left[free_slot] = r.burst_length;
				task_started[free_slot] = 0;
				o.admit_ok = 1;
			end
			return o;
		end
		if (cpu_busy && task_live[cpu_slot]) begin
			pick = shortest_task(cpu_slot);
			if (pick >= 0 && task_left[pick] < task_left[cpu_slot]) begin
				o.segment_valid = 1;
				o.segment_id = task_tag[cpu_slot];
				o.segment_length = run_units;
				cpu_slot = pick;
				run_units = 0;
			end
		end else begin
			pick = shortest_task(-1);
			cpu_busy = (pick >= 0);
			cpu_slot = (pick >= 0) ? pick : 0;
			run_units = 0;
		end
		if (!cpu_busy) begin
			now = clamp_inc(now);
			return o;
		end
		if (!task_started[cpu_slot]) begin
			task_started[cpu_slot] = 1;
			task_first_run[cpu_slot] = now;
		end
		o.run_valid = 1;
		o.run_id = task_tag[cpu_slot];
		if (task_left[cpu_slot] != 0)
			task_left[cpu_slot]--;
		run_units = clamp_inc(run_units);
		now = clamp_inc(now);
		if (task_left[cpu_slot] == 0) begin
			turn = clamp_sub(now, task_arrival[cpu_slot]);
			if (!o.segment_valid) begin
				o.segment_valid = 1;
				o.segment_id = task_tag[cpu_slot];
				o.segment_length = run_units;
			end
			o.done_valid = 1;
			o.done_id = task_tag[cpu_slot];
			o.completion_time = now;
			o.response_time = clamp_sub(task_first_run[cpu_slot], task_arrival[cpu_slot]);
			o.waiting_time = clamp_sub(turn, task_burst[cpu_slot]);
			o.turnaround_time = turn;
			task_live[cpu_slot] = 0;
			task_started[cpu_slot] = 0;
			cpu_busy = 0;
			cpu_slot = 0;
			run_units = 0;
		end
		return o;
	endfunction

	task automatic queue_item(logic op, logic [7:0] id, logic [15:0] burst, bit drain = 0);
		request_t r;
		r.operation = op;
		r.task_id = id;
		r.burst_length = burst;
		r.drain = drain;
		pending_items.insert(pending_items.size(), r);
	endtask

	task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
		$display("mismatch on %s at %0t: got %0d, expected %0d", field, $realtime, got, want);
		mismatches++;
	endtask

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		int idle_pct;
		if (!arst_n) begin
			in_valid <= 1'b0;
			operation <= OP_ADMIT;
			task_id <= '0;
			burst_length <= '0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) begin
				expected_outcomes.insert(expected_outcomes.size(),
					schedule_item('{operation, task_id, burst_length, 0}));
				items_sent++;
			end
			idle_pct = (items_sent < total_items / 3) ? 6 :
				(items_sent < 2 * total_items / 3) ? 66 : 0;
			if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct &&
					(!pending_items[0].drain || expected_outcomes.size() == 0)) begin
				in_valid <= 1'b1;
				operation <= pending_items[0].operation;
				task_id <= pending_items[0].task_id;
				burst_length <= pending_items[0].burst_length;
				void'(pending_items.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		int stall_pct;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			stall_pct = (items_sent < total_items / 3) ? 66 :
				(items_sent < 2 * total_items / 3) ? 6 : 0;
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
			if (out_valid && out_ready) begin
				if (expected_outcomes.size() == 0) begin
					report_mismatch("unexpected result", 16'd1, 16'd0);
				end else begin
					want = expected_outcomes.pop_front();
					if (admit_ok !== want.admit_ok)
						report_mismatch("admit_ok", admit_ok, want.admit_ok);
					if (run_valid !== want.run_valid)
						report_mismatch("run_valid", run_valid, want.run_valid);
					if (run_id !== want.run_id)
						report_mismatch("run_id", run_id, want.run_id);
					if (segment_valid !== want.segment_valid)
						report_mismatch("segment_valid", segment_valid, want.segment_valid);
					if (segment_id !== want.segment_id)
						report_mismatch("segment_id", segment_id, want.segment_id);
					if (segment_length !== want.segment_length)
						report_mismatch("segment_length", segment_length, want.segment_length);
					if (done_valid !== want.done_valid)
						report_mismatch("done_valid", done_valid, want.done_valid);
					if (done_id !== want.done_id)
						report_mismatch("done_id", done_id, want.done_id);
					if (completion_time !== want.completion_time)
						report_mismatch("completion_time", completion_time, want.completion_time);
					if (response_time !== want.response_time)
						report_mismatch("response_time", response_time, want.response_time);
					if (waiting_time !== want.waiting_time)
						report_mismatch("waiting_time", waiting_time, want.waiting_time);
					if (turnaround_time !== want.turnaround_time)
						report_mismatch("turnaround_time", turnaround_time, want.turnaround_time);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		mismatches = 0;
		items_sent = 0;
		cycles = 0;
		now = '0;
		cpu_busy = 0;
		cpu_slot = 0;
		run_units = '0;
		for (int i = 0; i < SLOTS; i++) begin
			task_live[i] = 0;
			task_started[i] = 0;
		end

		// directed: idle tick, zero burst, preemption, tie, extreme ids and bursts
		queue_item(OP_TICK, 8'h00, 16'h0000);
		queue_item(OP_ADMIT, 8'h12, 16'h0000);
		queue_item(OP_ADMIT, 8'h00, 16'd3);
		queue_item(OP_TICK, 8'hff, 16'hffff);
		queue_item(OP_ADMIT, 8'hff, 16'd1);
		queue_item(OP_TICK, 8'h00, 16'h0000);
		queue_item(OP_TICK, 8'h00, 16'h0000);
		queue_item(OP_ADMIT, 8'h5a, 16'd2);
		queue_item(OP_ADMIT, 8'ha5, 16'd2);
		for (int i = 0; i < 5; i++)
			queue_item(OP_TICK, 8'h00, 16'h0000);
		queue_item(OP_ADMIT, 8'haa, 16'hffff);
		queue_item(OP_ADMIT, 8'h55, 16'h5555);
		queue_item(OP_ADMIT, 8'h33, 16'haaaa);
		queue_item(OP_TICK, 8'h00, 16'h0000);

		// random: mostly short tasks, now and then a long one, sometimes a full table
		while (pending_items.size() < 1200) begin
			if ($urandom_range(0, 99) < 2) begin
				// fill the table past capacity, then run everything short to the end
				for (int i = 0; i < SLOTS + 2; i++)
					queue_item(OP_ADMIT, 8'($urandom_range(0, 255)), 16'($urandom_range(1, 3)));
				for (int i = 0; i < 3 * SLOTS + 8; i++)
					queue_item(OP_TICK, 8'($urandom_range(0, 255)),
						16'($urandom_range(0, 65535)));
			end else if ($urandom_range(0, 99) < 40) begin
				queue_item(OP_ADMIT, 8'($urandom_range(0, 255)),
					16'(($urandom_range(0, 99) < 2) ? $urandom_range(0, 65535) :
					$urandom_range(0, 8)));
			end else begin
				queue_item(OP_TICK, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
			end
		end
		// sender holds off until the block has caught up, once in each phase
		pending_items[pending_items.size() / 6].drain = 1;
		pending_items[pending_items.size() / 2].drain = 1;
		pending_items[5 * pending_items.size() / 6].drain = 1;
		total_items = pending_items.size();

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		wait (pending_items.size() == 0 && !in_valid);
		wait (expected_outcomes.size() == 0);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && expected_outcomes.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// File: filelist.f
+incdir+src
src/srts_pkg.sv
src/srts_table.sv
src/srts_ctrl.sv
src/shortest_remaining_time_scheduler_unit.sv
test/shortest_remaining_time_scheduler_unit_test.sv
